[rtl/pcc_pkg.sv]
package pcc_pkg;

	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int GAIN_W             = 16;
	localparam int CFG_IDX_W          = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_KP_GAIN  = 3'd0;
	localparam cfg_idx_t REG_KI_GAIN  = 3'd1;
	localparam cfg_idx_t REG_KD_GAIN  = 3'd2;
	localparam cfg_idx_t REG_REVERSE  = 3'd3;
	localparam cfg_idx_t REG_INCR     = 3'd4;
	localparam cfg_idx_t REG_OUT_MIN  = 3'd5;
	localparam cfg_idx_t REG_OUT_MAX  = 3'd6;

	localparam logic REQ_COMPUTE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;

	localparam logic [GAIN_W-1:0] KP_GAIN_RESET = 16'd256;

endpackage

[rtl/pcc_sample_if.sv]
interface pcc_sample_if
	import pcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [SAMPLE_BITS-1:0] setpoint;
	logic [SAMPLE_BITS-1:0] measurement;

	modport source (output valid, output req_type, output setpoint, output measurement,
		input ready);
	modport sink (input valid, input req_type, input setpoint, input measurement,
		output ready);
endinterface

[rtl/pcc_result_if.sv]
interface pcc_result_if
	import pcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] drive;
	logic                   clamped;

	modport source (output valid, output drive, output clamped, input ready);
	modport sink (input valid, input drive, input clamped, output ready);
endinterface

[rtl/pcc_cfg_if.sv]
interface pcc_cfg_if
	import pcc_pkg::*;
#(
	parameter int DATA_W = GAIN_W
);
	logic              valid;
	logic              ready;
	cfg_idx_t          index;
	logic [DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/pid_controller_clamped_top.sv]
// Clamped PID controller with derivative on measurement. Each sample item gives one
// result item; a new sample is taken every clock unless the result side stalls. The
// gain multiplies (kp and kd on the error and measurement change, ki on the error)
// run at input acceptance into the input register; the integral add-clamp, the drive
// sum, the arithmetic shift by GAIN_FRAC_BITS, the optional incremental add and the
// output clamp run as the input register advances into the result register, so the
// integral/drive recurrence closes through the result-stage registers. A clear item
// zeroes the integral and previous drive, returns drive 0 with clamped 0. The config
// port is always ready (uses cfg.data[max(16, S)-1:0]); write it only while idle.
module pid_controller_clamped_top
	import pcc_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	pcc_sample_if.sink  smp,
	pcc_result_if.source res,
	pcc_cfg_if.sink     cfg
);
	localparam int S  = SAMPLE_BITS;
	localparam int F  = GAIN_FRAC_BITS;
	localparam int PW = S + GAIN_W + 2;
	localparam int IW = S + F;
	localparam int W  = S + F + 20;

	// configuration
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic              rev_q, inc_q;
	logic signed [S-1:0] out_min_q, out_max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= KP_GAIN_RESET;
			ki_q      <= '0;
			kd_q      <= '0;
			rev_q     <= 1'b0;
			inc_q     <= 1'b0;
			out_min_q <= {1'b1, {(S-1){1'b0}}};
			out_max_q <= {1'b0, {(S-1){1'b1}}};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KP_GAIN: kp_q      <= cfg.data[GAIN_W-1:0];
				REG_KI_GAIN: ki_q      <= cfg.data[GAIN_W-1:0];
				REG_KD_GAIN: kd_q      <= cfg.data[GAIN_W-1:0];
				REG_REVERSE: rev_q     <= cfg.data[0];
				REG_INCR:    inc_q     <= cfg.data[0];
				REG_OUT_MIN: out_min_q <= cfg.data[S-1:0];
				REG_OUT_MAX: out_max_q <= cfg.data[S-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic v_s1, clr_s1, res_v_q, clr_s2, adv, in_acc;

	assign adv       = v_s1 && (!res_v_q || res.ready);
	assign smp.ready = !v_s1 || adv;
	assign in_acc    = smp.valid && smp.ready;

	// input side: error, measurement change and gain products
	logic signed [S-1:0]      sp_in, meas_in, mlast_q;
	logic signed [S:0]        err, dmeas;
	logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
	logic signed [PW-1:0]     kp_err, ki_err, kd_dm;
	logic signed [PW:0]       pterm_s1;
	logic signed [PW-1:0]     iterm_s1;

	assign sp_in   = smp.setpoint;
	assign meas_in = smp.measurement;
	assign err     = (S+1)'(sp_in) - (S+1)'(meas_in);
	assign dmeas   = (S+1)'(meas_in) - (S+1)'(mlast_q);

	always_comb begin
		kp_s = $signed({1'b0, kp_q});
		ki_s = $signed({1'b0, ki_q});
		kd_s = $signed({1'b0, kd_q});
		if (rev_q) begin
			kp_s = -kp_s;
			ki_s = -ki_s;
			kd_s = -kd_s;
		end
	end

	assign kp_err = PW'(kp_s) * PW'(err);
	assign ki_err = PW'(ki_s) * PW'(err);
	assign kd_dm  = PW'(kd_s) * PW'(dmeas);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			clr_s1  <= 1'b0;
			mlast_q <= '0;
		end else begin
			if (in_acc) begin
				v_s1   <= 1'b1;
				clr_s1 <= smp.req_type == REQ_CLEAR;
				if (smp.req_type == REQ_COMPUTE)
					mlast_q <= meas_in;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pterm_s1 <= (PW+1)'(kp_err) - (PW+1)'(kd_dm);
			iterm_s1 <= ki_err;
		end
	end

	// recurrence: integral clamp, drive sum, shift, incremental add, clamp
	logic signed [IW-1:0] integ_q, integ_nx;
	logic signed [S-1:0]  pdrive_q, drive_nx;
	logic signed [W-1:0]  int_lo, int_hi, isum, isum_cl;
	logic signed [W-1:0]  dsum, dshift, pd_add, dinc, dcl, lim_lo, lim_hi;
	logic                 hit;

	assign lim_lo = W'(out_min_q);
	assign lim_hi = W'(out_max_q);
	assign int_lo = lim_lo <<< F;
	assign int_hi = lim_hi <<< F;
	assign isum   = W'(integ_q) + W'(iterm_s1);

	always_comb begin
		// upper limit checked first: with crossed limits a sum above it takes it, else lower
		if (isum > int_hi)
			isum_cl = int_hi;
		else if (isum < int_lo)
			isum_cl = int_lo;
		else
			isum_cl = isum;
	end

	assign integ_nx = isum_cl[IW-1:0];
	assign dsum     = W'(pterm_s1) + W'(integ_nx);
	assign dshift   = dsum >>> F;
	assign pd_add   = inc_q ? W'(pdrive_q) : W'(0);
	assign dinc     = dshift + pd_add;

	always_comb begin
		hit = 1'b1;
		if (dinc > lim_hi)
			dcl = lim_hi;
		else if (dinc < lim_lo)
			dcl = lim_lo;
		else begin
			dcl = dinc;
			hit = 1'b0;
		end
	end

	assign drive_nx = dcl[S-1:0];

	logic [S-1:0] drive_s2;
	logic         clamped_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			pdrive_q <= '0;
			res_v_q  <= 1'b0;
			clr_s2   <= 1'b0;
		end else begin
			if (adv) begin
				res_v_q <= 1'b1;
				clr_s2  <= clr_s1;
				if (clr_s1) begin
					integ_q  <= '0;
					pdrive_q <= '0;
				end else begin
					integ_q  <= integ_nx;
					pdrive_q <= drive_nx;
				end
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_s2   <= clr_s1 ? '0 : drive_nx;
			clamped_s2 <= clr_s1 ? 1'b0 : hit;
		end
	end

	assign res.valid   = res_v_q;
	assign res.drive   = drive_s2;
	assign res.clamped = clamped_s2;

	// checks
	a_unclamped_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !clr_s2 && !clamped_s2 |->
		$signed(drive_s2) <= out_max_q && $signed(drive_s2) >= out_min_q)
		else $error("unclamped drive outside limits");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(pterm_s1) && $stable(clr_s1))
		else $error("input register lost a stalled item");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!smp.ready |-> v_s1 && res_v_q && !res.ready)
		else $error("input stalled while pipeline has room");

endmodule
